// ===== sv/ssm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the subkey score merge block.
package ssm_pkg;

  localparam int unsigned NUM_SUBKEYS_DEF       = 16;
  localparam int unsigned VALUES_PER_SUBKEY_DEF = 256;

  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SUBKEY_W = 4;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned INDEX_W  = 24;
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned MF_W     = 2;
  localparam int unsigned FIRST_W  = 7;
  localparam int unsigned MEMBERS  = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_SCORE  = 2'd0,
    ACT_LOAD_KEY    = 2'd1,
    ACT_QUERY_SCORE = 2'd2,
    ACT_QUERY_KEY   = 2'd3
  } action_e;

  typedef struct packed {
    action_e                    action;
    logic [SUBKEY_W-1:0]        subkey;
    logic [VALUE_W-1:0]         value_index;
    logic signed [SCORE_W-1:0]  score;
    logic [GROUP_W-1:0]         group;
    logic [INDEX_W-1:0]         merged_index;
  } in_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] merged_score;
    logic [KEY_W-1:0]        merged_key;
    logic                    out_of_range;
  } out_req_t;

  typedef struct packed {
    logic               is_query;
    logic               load_ok;
    logic               oor;
    logic [FIRST_W-1:0] first;
    logic [1:0]         size;
  } dec_t;

endpackage

// ===== sv/subkey_score_merge_core.sv =====
`timescale 1ns / 1ps
// Top level: six-stage subkey score merge pipeline with score and true key tables.
//
// Input channel: in_valid_i / in_stall_o carry one request (in_req_i) per cycle.
// Loads (score, true key value) write the tables and give no result; queries
// (merged score, true merged key) give exactly one result on out_valid_o /
// out_stall_i with payload out_req_o.
// A query result passes from the stage 1 register through stages 2 to 5 into the
// output register. Throughput: one request per cycle while in_stall_o is low.
// The tables are read in two stages: the true key store in stage 1, the score
// table in stage 4, each through three read copies so a three-member group is
// read in a single access. Digits of the merged index are split by a reciprocal
// multiply by the values per subkey, one multiply per stage.
// Reset: pipeline empties, merge factor returns to 1; table contents are
// undefined until loaded. The user must write merge_factor through cfg_we_i only
// while idle; the block does not enforce this.
// Stall: results stay in the output register; empty stages ahead close up, and
// in_stall_o rises only when all six stages hold requests and out_stall_i is high.
module subkey_score_merge_core #(
  parameter int unsigned NUM_SUBKEYS       = ssm_pkg::NUM_SUBKEYS_DEF,
  parameter int unsigned VALUES_PER_SUBKEY = ssm_pkg::VALUES_PER_SUBKEY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ssm_pkg::MF_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ssm_pkg::in_req_t         in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ssm_pkg::out_req_t        out_req_o
);
  import ssm_pkg::*;

  localparam int unsigned SK_W   = (NUM_SUBKEYS > 1) ? $clog2(NUM_SUBKEYS) : 1;
  localparam int unsigned DEPTH  = NUM_SUBKEYS * VALUES_PER_SUBKEY;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DIG_W  = $clog2(VALUES_PER_SUBKEY);
  localparam int unsigned VV     = VALUES_PER_SUBKEY * VALUES_PER_SUBKEY;

  // control
  logic [MF_W-1:0] mf_q, mf_d;
  logic [6:1]      v_q, v_d;
  logic [6:1]      ct;
  logic [5:1]      mv;

  dec_t in_dec;

  // stage 1
  in_req_t s1_req_q;
  dec_t    s1_dec_q;
  // stage 2
  action_e             s2_act_q;
  dec_t                s2_dec_q;
  logic [INDEX_W-1:0]  s2_j_q, s2_q1_q;
  logic [ADDR_W-1:0]   s2_base_q [MEMBERS];
  logic [ADDR_W-1:0]   s2_ld_addr_q;
  logic [SCORE_W-1:0]  s2_score_q;
  // stage 3
  action_e             s3_act_q;
  dec_t                s3_dec_q;
  logic [INDEX_W-1:0]  s3_j_q, s3_q1_q, s3_q2_q, s3_q1v_q;
  logic [ADDR_W-1:0]   s3_base_q [MEMBERS];
  logic [ADDR_W-1:0]   s3_ld_addr_q;
  logic [SCORE_W-1:0]  s3_score_q;
  logic [VALUE_W-1:0]  s3_tk_q [MEMBERS];
  logic [KEY_W-1:0]    s3_key_q;
  // stage 4
  action_e             s4_act_q;
  dec_t                s4_dec_q;
  logic [INDEX_W-1:0]  s4_q1_q, s4_q2_q, s4_q2v_q;
  logic [DIG_W-1:0]    s4_d0_q;
  logic [ADDR_W-1:0]   s4_base_q [MEMBERS];
  logic [ADDR_W-1:0]   s4_ld_addr_q;
  logic [SCORE_W-1:0]  s4_score_q;
  logic [VALUE_W-1:0]  s4_tk_q [MEMBERS];
  logic [KEY_W-1:0]    s4_key_q;
  // stage 5
  action_e             s5_act_q;
  dec_t                s5_dec_q;
  logic [KEY_W-1:0]    s5_key_q;
  // stage 6
  out_req_t            out_q, out_d;

  // combinational
  logic [INDEX_W-1:0]  q1, q2, q1v, q2v;
  logic [ADDR_W-1:0]   base_d [MEMBERS];
  logic [ADDR_W-1:0]   ld_addr_d;
  logic [KEY_W-1:0]    key_d;
  logic [DIG_W-1:0]    d0, d1, d2;
  logic [DIG_W-1:0]    dig [MEMBERS];
  logic [ADDR_W-1:0]   sc_raddr [MEMBERS];
  logic [SCORE_W-1:0]  sc_rd [MEMBERS];
  logic [SK_W-1:0]     tk_raddr [MEMBERS];
  logic [VALUE_W-1:0]  tk_rd [MEMBERS];
  logic                tk_we, tk_re, sc_we, sc_re;
  logic signed [SUM_W-1:0] sum;

  // flow control: a stage takes a request when empty or moving on
  always_comb begin
    ct[6] = !v_q[6] || !out_stall_i;
    for (int k = 5; k >= 1; k--) begin
      ct[k] = !v_q[k] || ct[k+1];
    end
    for (int k = 1; k <= 5; k++) begin
      mv[k] = v_q[k] && ct[k+1];
    end
    v_d[1] = ct[1] ? in_valid_i : v_q[1];
    for (int k = 2; k <= 5; k++) begin
      v_d[k] = ct[k] ? v_q[k-1] : v_q[k];
    end
    v_d[6] = ct[6] ? (v_q[5] && s5_dec_q.is_query) : v_q[6];
    mf_d   = cfg_we_i ? cfg_wdata_i : mf_q;
  end

  assign in_stall_o  = !ct[1];
  assign out_valid_o = v_q[6];
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      mf_q <= MF_W'(1);
    end else begin
      v_q  <= v_d;
      mf_q <= mf_d;
    end
  end

  ssm_decode #(
    .NUM_SUBKEYS      (NUM_SUBKEYS),
    .VALUES_PER_SUBKEY(VALUES_PER_SUBKEY)
  ) u_decode (
    .req_i(in_req_i),
    .mf_i (mf_q),
    .dec_o(in_dec)
  );

  // stage 1: true key store access, first digit split, address bases
  ssm_divc #(.VALUES_PER_SUBKEY(VALUES_PER_SUBKEY)) u_div1 (
    .n_i(s1_req_q.merged_index),
    .q_o(q1)
  );

  assign tk_we = mv[1] && (s1_req_q.action == ACT_LOAD_KEY) && s1_dec_q.load_ok;
  assign tk_re = mv[1] && s1_dec_q.is_query;

  always_comb begin
    for (int k = 0; k < MEMBERS; k++) begin
      tk_raddr[k] = SK_W'(s1_dec_q.first + FIRST_W'(k));
      base_d[k]   = ADDR_W'(32'(s1_dec_q.first + FIRST_W'(k)) * 32'(VALUES_PER_SUBKEY));
    end
    ld_addr_d = ADDR_W'(32'(s1_req_q.subkey) * 32'(VALUES_PER_SUBKEY)
                        + 32'(s1_req_q.value_index));
  end

  for (genvar k = 0; k < MEMBERS; k++) begin : g_tk
    ssm_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_SUBKEYS)) u_tk_ram (
      .clk_i  (clk_i),
      .we_i   (tk_we),
      .waddr_i(SK_W'(s1_req_q.subkey)),
      .wdata_i(s1_req_q.value_index),
      .re_i   (tk_re),
      .raddr_i(tk_raddr[k]),
      .rdata_o(tk_rd[k])
    );
  end

  // stage 2: second digit split, key packing
  ssm_divc #(.VALUES_PER_SUBKEY(VALUES_PER_SUBKEY)) u_div2 (
    .n_i(s2_q1_q),
    .q_o(q2)
  );

  assign q1v = INDEX_W'(32'(s2_q1_q) * 32'(VALUES_PER_SUBKEY));

  always_comb begin
    case (s2_dec_q.size)
      2'd1:    key_d = KEY_W'(tk_rd[0]);
      2'd2:    key_d = KEY_W'(32'(tk_rd[0]) * 32'(VALUES_PER_SUBKEY) + 32'(tk_rd[1]));
      default: key_d = KEY_W'(32'(tk_rd[0]) * 32'(VV)
                              + 32'(tk_rd[1]) * 32'(VALUES_PER_SUBKEY) + 32'(tk_rd[2]));
    endcase
  end

  // stage 3: low digit, product for middle digit
  assign d0  = DIG_W'(s3_j_q - s3_q1v_q);
  assign q2v = INDEX_W'(32'(s3_q2_q) * 32'(VALUES_PER_SUBKEY));

  // stage 4: digit select, score table access
  assign d1 = DIG_W'(s4_q1_q - s4_q2v_q);
  assign d2 = DIG_W'(s4_q2_q);

  always_comb begin
    for (int k = 0; k < MEMBERS; k++) begin
      dig[k] = DIG_W'(s4_tk_q[k]);
    end
    if (s4_act_q == ACT_QUERY_SCORE) begin
      case (s4_dec_q.size)
        2'd1: begin
          dig[0] = s4_d0_q;
        end
        2'd2: begin
          dig[0] = d1;
          dig[1] = s4_d0_q;
        end
        default: begin
          dig[0] = d2;
          dig[1] = d1;
          dig[2] = s4_d0_q;
        end
      endcase
    end
    for (int k = 0; k < MEMBERS; k++) begin
      sc_raddr[k] = s4_base_q[k] + ADDR_W'(dig[k]);
    end
  end

  assign sc_we = mv[4] && (s4_act_q == ACT_LOAD_SCORE) && s4_dec_q.load_ok;
  assign sc_re = mv[4] && s4_dec_q.is_query;

  for (genvar k = 0; k < MEMBERS; k++) begin : g_sc
    ssm_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_sc_ram (
      .clk_i  (clk_i),
      .we_i   (sc_we),
      .waddr_i(s4_ld_addr_q),
      .wdata_i(s4_score_q),
      .re_i   (sc_re),
      .raddr_i(sc_raddr[k]),
      .rdata_o(sc_rd[k])
    );
  end

  // stage 5: sum of member scores
  always_comb begin
    sum = '0;
    for (int k = 0; k < MEMBERS; k++) begin
      if (2'(k) < s5_dec_q.size) begin
        sum = sum + SUM_W'($signed(sc_rd[k]));
      end
    end
    if (s5_dec_q.oor) begin
      out_d.merged_score = '0;
      out_d.merged_key   = '0;
      out_d.out_of_range = 1'b1;
    end else begin
      out_d.merged_score = sum;
      out_d.merged_key   = (s5_act_q == ACT_QUERY_KEY) ? s5_key_q : '0;
      out_d.out_of_range = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ct[1]) begin
      s1_req_q <= in_req_i;
      s1_dec_q <= in_dec;
    end
    if (ct[2]) begin
      s2_act_q     <= s1_req_q.action;
      s2_dec_q     <= s1_dec_q;
      s2_j_q       <= s1_req_q.merged_index;
      s2_q1_q      <= q1;
      s2_base_q    <= base_d;
      s2_ld_addr_q <= ld_addr_d;
      s2_score_q   <= s1_req_q.score;
    end
    if (ct[3]) begin
      s3_act_q     <= s2_act_q;
      s3_dec_q     <= s2_dec_q;
      s3_j_q       <= s2_j_q;
      s3_q1_q      <= s2_q1_q;
      s3_q2_q      <= q2;
      s3_q1v_q     <= q1v;
      s3_base_q    <= s2_base_q;
      s3_ld_addr_q <= s2_ld_addr_q;
      s3_score_q   <= s2_score_q;
      s3_tk_q      <= tk_rd;
      s3_key_q     <= key_d;
    end
    if (ct[4]) begin
      s4_act_q     <= s3_act_q;
      s4_dec_q     <= s3_dec_q;
      s4_q1_q      <= s3_q1_q;
      s4_q2_q      <= s3_q2_q;
      s4_q2v_q     <= q2v;
      s4_d0_q      <= d0;
      s4_base_q    <= s3_base_q;
      s4_ld_addr_q <= s3_ld_addr_q;
      s4_score_q   <= s3_score_q;
      s4_tk_q      <= s3_tk_q;
      s4_key_q     <= s3_key_q;
    end
    if (ct[5]) begin
      s5_act_q <= s4_act_q;
      s5_dec_q <= s4_dec_q;
      s5_key_q <= s4_key_q;
    end
    if (ct[6]) begin
      out_q <= out_d;
    end
  end

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.out_of_range
      |-> (out_req_o.merged_score == '0) && (out_req_o.merged_key == '0))
    else $error("out-of-range result carries nonzero payload");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_sc_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sc_we && sc_re))
    else $error("score table written and read by one stage at once");

  a_tk_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tk_we && tk_re))
    else $error("true key store written and read by one stage at once");

endmodule

// ===== sv/ssm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ssm_divc.sv =====
`timescale 1ns / 1ps
// Divide a 24-bit index by VALUES_PER_SUBKEY through a reciprocal multiply.
module ssm_divc #(
  parameter int unsigned VALUES_PER_SUBKEY = ssm_pkg::VALUES_PER_SUBKEY_DEF
) (
  input  logic [ssm_pkg::INDEX_W-1:0] n_i,
  output logic [ssm_pkg::INDEX_W-1:0] q_o
);
  import ssm_pkg::*;

  // floor(n*R / 2^SHIFT) == floor(n/V) for all n < 2^INDEX_W
  localparam int unsigned LOG_V   = $clog2(VALUES_PER_SUBKEY);
  localparam int unsigned SHIFT   = INDEX_W + LOG_V;
  localparam int unsigned RECIP_W = INDEX_W + 2;
  localparam int unsigned PROD_W  = INDEX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << SHIFT) / VALUES_PER_SUBKEY + 64'd1);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(n_i) * PROD_W'(RECIP);
  assign q_o  = INDEX_W'(prod >> SHIFT);

endmodule

// ===== sv/ssm_decode.sv =====
`timescale 1ns / 1ps
// Request decode: group bounds, member range, list length and load checks.
module ssm_decode #(
  parameter int unsigned NUM_SUBKEYS       = ssm_pkg::NUM_SUBKEYS_DEF,
  parameter int unsigned VALUES_PER_SUBKEY = ssm_pkg::VALUES_PER_SUBKEY_DEF
) (
  input  ssm_pkg::in_req_t          req_i,
  input  logic [ssm_pkg::MF_W-1:0]  mf_i,
  output ssm_pkg::dec_t             dec_o
);
  import ssm_pkg::*;

  localparam int unsigned GROUPS1 = NUM_SUBKEYS;
  localparam int unsigned GROUPS2 = (NUM_SUBKEYS + 1) / 2;
  localparam int unsigned GROUPS3 = (NUM_SUBKEYS + 2) / 3;
  localparam logic [INDEX_W:0] LEN1 = (INDEX_W+1)'(VALUES_PER_SUBKEY);
  localparam logic [INDEX_W:0] LEN2 = (INDEX_W+1)'(VALUES_PER_SUBKEY * VALUES_PER_SUBKEY);
  localparam logic [INDEX_W:0] LEN3 =
    (INDEX_W+1)'(VALUES_PER_SUBKEY * VALUES_PER_SUBKEY * VALUES_PER_SUBKEY);

  logic [FIRST_W-1:0] first;
  logic [FIRST_W-1:0] groups;
  logic [FIRST_W-1:0] remaining;
  logic [1:0]         size;
  logic [INDEX_W:0]   len;
  logic               grp_bad;
  logic               idx_bad;

  always_comb begin
    first  = '0;
    groups = '0;
    unique case (mf_i)
      2'd1: begin
        first  = FIRST_W'(req_i.group);
        groups = FIRST_W'(GROUPS1);
      end
      2'd2: begin
        first  = FIRST_W'({req_i.group, 1'b0});
        groups = FIRST_W'(GROUPS2);
      end
      2'd3: begin
        first  = FIRST_W'(req_i.group) + FIRST_W'({req_i.group, 1'b0});
        groups = FIRST_W'(GROUPS3);
      end
      default: begin
        first  = '0;
        groups = '0;
      end
    endcase

    grp_bad   = FIRST_W'(req_i.group) >= groups;
    remaining = FIRST_W'(NUM_SUBKEYS) - first;
    size      = (remaining < FIRST_W'(mf_i)) ? remaining[1:0] : mf_i;

    case (size)
      2'd1:    len = LEN1;
      2'd2:    len = LEN2;
      default: len = LEN3;
    endcase
    idx_bad = {1'b0, req_i.merged_index} >= len;

    dec_o.is_query = (req_i.action == ACT_QUERY_SCORE) || (req_i.action == ACT_QUERY_KEY);
    dec_o.load_ok  = (FIRST_W'(req_i.subkey) < FIRST_W'(NUM_SUBKEYS))
                  && ((VALUE_W+1)'(req_i.value_index) < (VALUE_W+1)'(VALUES_PER_SUBKEY));
    dec_o.oor      = grp_bad || ((req_i.action == ACT_QUERY_SCORE) && idx_bad);
    dec_o.first    = first;
    dec_o.size     = size;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for subkey_score_merge_core: directed and random requests checked by a merge predictor.
module tb;
  import ssm_pkg::*;

  localparam int unsigned NSK = NUM_SUBKEYS_DEF;
  localparam int unsigned NVAL = VALUES_PER_SUBKEY_DEF;
  localparam int unsigned DRAIN = 12;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned HOLD_LEN = 80;
  localparam int unsigned NPHASE = 7;
  localparam logic [MF_W-1:0] PLAN [NPHASE] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};
  localparam logic [SCORE_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] S_MAX = 32'h7FFF_FFFF;

  class merge_checker;
    logic signed [SCORE_W-1:0] scores [NSK][NVAL];
    logic [VALUE_W-1:0] true_vals [NSK];
    logic [MF_W-1:0] factor;
    out_req_t merged_due [$];
    int errors;

    function new();
      factor = 2'd1;
      errors = 0;
    endfunction

    function int pending();
      return merged_due.size();
    endfunction

    function out_req_t merge_for(in_req_t r);
      out_req_t res;
      int unsigned m, groups, first, size, len;
      longint sum;
      logic [KEY_W-1:0] key;
      logic [VALUE_W-1:0] digit, tv;
      res = '0;
      res.out_of_range = 1'b1;
      m = factor;
      if (m == 0) return res;
      groups = (NSK + m - 1) / m;
      if (r.group >= groups) return res;
      first = r.group * m;
      size = (NSK - first < m) ? NSK - first : m;
      sum = 0;
      key = '0;
      if (r.action == ACT_QUERY_SCORE) begin
        len = 1 << (VALUE_W * size);
        if (r.merged_index >= len) return res;
        for (int k = 0; k < size; k++) begin
          digit = VALUE_W'(r.merged_index >> (VALUE_W * (size - 1 - k)));
          sum += scores[first + k][digit];
        end
      end else begin
        for (int k = 0; k < size; k++) begin
          tv = true_vals[first + k];
          key = (key << VALUE_W) | KEY_W'(tv);
          sum += scores[first + k][tv];
        end
      end
      res.merged_score = sum[SUM_W-1:0];
      res.merged_key = key;
      res.out_of_range = 1'b0;
      return res;
    endfunction

    function void note_request(in_req_t r);
      case (r.action)
        ACT_LOAD_SCORE: scores[r.subkey][r.value_index] = r.score;
        ACT_LOAD_KEY: true_vals[r.subkey] = r.value_index;
        default: merged_due.push_back(merge_for(r));
      endcase
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      if (merged_due.size() == 0) begin
        report($sformatf("result with nothing pending: score %0d key %h oor %b",
                         got.merged_score, got.merged_key, got.out_of_range));
        return;
      end
      want = merged_due.pop_front();
      if (got.merged_score !== want.merged_score)
        report($sformatf("merged_score %0d, want %0d", got.merged_score, want.merged_score));
      if (got.merged_key !== want.merged_key)
        report($sformatf("merged_key %h, want %h", got.merged_key, want.merged_key));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("out_of_range %b, want %b", got.out_of_range, want.out_of_range));
    endtask
  endclass

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [MF_W-1:0] cfg_wdata;
  logic in_valid, in_stall;
  in_req_t in_req;
  logic out_valid, out_stall;
  out_req_t out_req;

  merge_checker chk;
  bit score_set [NSK][NVAL];
  logic [VALUE_W-1:0] written_list [NSK][NVAL];
  int unsigned n_written [NSK];
  bit key_set [NSK];
  logic [VALUE_W-1:0] key_vals [NSK];
  logic [MF_W-1:0] cur_factor;
  bit calm;
  int hold_left;

  subkey_score_merge_core dut (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_req_i(in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o(out_req)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic in_req_t mk(action_e a, int unsigned sk, int unsigned vi,
                                 logic [SCORE_W-1:0] sc, int unsigned g, int unsigned j);
    in_req_t r;
    r.action = a;
    r.subkey = sk[SUBKEY_W-1:0];
    r.value_index = vi[VALUE_W-1:0];
    r.score = sc;
    r.group = g[GROUP_W-1:0];
    r.merged_index = j[INDEX_W-1:0];
    return r;
  endfunction

  // keep track of which table entries hold data, so queries never read unwritten ones
  function automatic void track(in_req_t r);
    if (r.action == ACT_LOAD_SCORE && !score_set[r.subkey][r.value_index]) begin
      score_set[r.subkey][r.value_index] = 1'b1;
      written_list[r.subkey][n_written[r.subkey]] = r.value_index;
      n_written[r.subkey]++;
    end else if (r.action == ACT_LOAD_KEY) begin
      key_set[r.subkey] = 1'b1;
      key_vals[r.subkey] = r.value_index;
    end
  endfunction

  function automatic in_req_t next_req();
    in_req_t r;
    logic [95:0] raw;
    logic [INDEX_W-1:0] idx;
    int unsigned pick, m, groups, first, size, len, sk;
    raw = {$urandom(), $urandom(), $urandom()};
    r = raw[$bits(in_req_t)-1:0];
    m = cur_factor;
    pick = $urandom_range(99);
    if (pick < 28) begin
      r.action = ACT_LOAD_SCORE;
      pick = $urandom_range(99);
      if (pick < 40 && key_set[r.subkey]) r.value_index = key_vals[r.subkey];
      else if (pick < 70) r.value_index = $urandom_range(3);
      return r;
    end
    if (pick < 36) begin
      r.action = ACT_LOAD_KEY;
      return r;
    end
    r.action = (pick < 68) ? ACT_QUERY_SCORE : ACT_QUERY_KEY;
    if (m == 0) return r;
    groups = (NSK + m - 1) / m;
    if ($urandom_range(99) < 15) begin
      if (groups < NSK && $urandom_range(1) == 1) begin
        r.group = $urandom_range(NSK - 1, groups);
        return r;
      end
      if (r.action == ACT_QUERY_SCORE) begin
        r.group = (m == 3) ? groups - 1 : $urandom_range(groups - 1);
        size = (m == 3) ? 1 : m;
        len = 1 << (VALUE_W * size);
        r.merged_index = $urandom_range((1 << INDEX_W) - 1, len);
        return r;
      end
    end
    r.group = $urandom_range(groups - 1);
    first = r.group * m;
    size = (NSK - first < m) ? NSK - first : m;
    idx = '0;
    for (int k = 0; k < size; k++) begin
      sk = first + k;
      if (r.action == ACT_QUERY_KEY) begin
        // fill in whatever the true key lookup still lacks
        if (!key_set[sk]) begin
          r.action = ACT_LOAD_KEY;
          r.subkey = sk;
          return r;
        end
        if (!score_set[sk][key_vals[sk]]) begin
          r.action = ACT_LOAD_SCORE;
          r.subkey = sk;
          r.value_index = key_vals[sk];
          return r;
        end
      end else begin
        if (n_written[sk] == 0) begin
          r.action = ACT_LOAD_SCORE;
          r.subkey = sk;
          return r;
        end
        idx = (idx << VALUE_W) |
              INDEX_W'(written_list[sk][$urandom_range(n_written[sk] - 1)]);
      end
    end
    if (r.action == ACT_QUERY_SCORE) r.merged_index = idx;
    return r;
  endfunction

  task automatic send(input in_req_t r);
    track(r);
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
  endtask

  task automatic set_factor(input logic [MF_W-1:0] f);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_factor = f;
  endtask

  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_we) chk.factor = cfg_wdata;
      if (in_valid && !in_stall) chk.note_request(in_req);
      if (out_valid && !out_stall) chk.check_result(out_req);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 31);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    chk = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req = '0;
    calm = 1'b0;
    hold_left = 0;
    cur_factor = 2'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // extreme scores at both ends of the value range, true keys at the top and bottom
    send(mk(ACT_LOAD_SCORE, 0, 0, S_MIN, 0, 0));
    send(mk(ACT_LOAD_SCORE, 1, 0, S_MIN, 0, 0));
    send(mk(ACT_LOAD_SCORE, 2, 0, S_MIN, 0, 0));
    send(mk(ACT_LOAD_SCORE, 0, 255, S_MAX, 0, 0));
    send(mk(ACT_LOAD_SCORE, 1, 255, S_MAX, 0, 0));
    send(mk(ACT_LOAD_SCORE, 2, 255, S_MAX, 0, 0));
    send(mk(ACT_LOAD_SCORE, 15, 255, S_MAX, 0, 0));
    send(mk(ACT_LOAD_SCORE, 15, 0, S_MIN, 0, 0));
    send(mk(ACT_LOAD_KEY, 0, 255, 0, 0, 0));
    send(mk(ACT_LOAD_KEY, 1, 255, 0, 0, 0));
    send(mk(ACT_LOAD_KEY, 2, 255, 0, 0, 0));
    send(mk(ACT_LOAD_KEY, 15, 0, 0, 0, 0));
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 15, 255));
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 0, 256));
    send(mk(ACT_QUERY_KEY, 0, 0, 0, 15, 0));
    send(mk(ACT_QUERY_KEY, 0, 0, 0, 0, 0));
    set_factor(2'd3);
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 0, 24'hFF_FFFF));
    send(mk(ACT_QUERY_KEY, 0, 0, 0, 0, 0));
    // short trailing group: subkey 15 alone
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 5, 0));
    send(mk(ACT_QUERY_SCORE, 0, 0, 0, 5, 256));
    send(mk(ACT_QUERY_KEY, 0, 0, 0, 6, 0));
    set_factor(2'd0);
    send(mk(ACT_QUERY_KEY, 0, 0, 0, 0, 0));

    for (int p = 0; p < NPHASE; p++) begin
      set_factor(PLAN[p]);
      calm = (p == 2);
      if (p == 1) hold_left = HOLD_LEN;
      repeat (PHASE_LEN) begin
        sender_gap();
        send(next_req());
      end
    end

    in_valid <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (chk.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
